FILE: rtl/character_set_bitmap_macros.svh
// assertion macros for the character set bitmap checker
// expects signals named clk and arst_n in the scope of use
`ifndef CHARACTER_SET_BITMAP_MACROS_SVH
`define CHARACTER_SET_BITMAP_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CSB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// next-cycle implication, sampled on clk, off while in reset
`define CSB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

FILE: rtl/csb_pkg.sv
// shared types and constants for the character set bitmap
// no dependencies
package csb_pkg;

	localparam int PAGE_COUNT_DEF = 256;
	localparam int WORD_BITS_DEF  = 64;
	localparam int PAGE_BITS      = 256;
	localparam int CODE_W         = 21;
	localparam int CMD_W          = 3;
	localparam int STATUS_W       = 2;

	localparam logic [CMD_W-1:0] CMD_SET_CODE  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CLR_CODE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SET_RANGE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLR_RANGE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FILL      = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLR_ALL   = 3'd5;
	localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd6;

	localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BEYOND   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REVERSED = 2'd2;

	// operation handed to the merge unit for each word it touches
	typedef struct packed {
		logic [CODE_W-1:0] first_code;
		logic [CODE_W-1:0] last_code;
		logic              set_val;
	} op_t;

endpackage

FILE: rtl/csb_if.sv
// valid/ready channel interfaces for commands and results
// depends on csb_pkg
interface csb_req_if;
	logic                       valid;
	logic                       ready;
	logic [csb_pkg::CMD_W-1:0]  command;
	logic [csb_pkg::CODE_W-1:0] first_code;
	logic [csb_pkg::CODE_W-1:0] last_code;

	modport source (output valid, command, first_code, last_code, input ready);
	modport sink   (input valid, command, first_code, last_code, output ready);
endinterface

interface csb_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         member;
	logic [csb_pkg::STATUS_W-1:0] status;

	modport source (output valid, member, status, input ready);
	modport sink   (input valid, member, status, output ready);
endinterface

FILE: rtl/character_set_bitmap.sv
// character set bitmap: membership bit per code point, held in a word ram
// set/clear/query and ranges: ram read then write state per storage word (no write for
// a query), then done state and result register; next command taken once result is loaded
// fill and clear all write every storage word, one word per cycle, then go to done
// reset: after arst_n releases, a clearing pass over all PAGE_COUNT*256/WORD_BITS words
// (1024 by default) empties the set; no command is accepted until it ends
module character_set_bitmap #(
	parameter int PAGE_COUNT = csb_pkg::PAGE_COUNT_DEF,
	parameter int WORD_BITS  = csb_pkg::WORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	csb_req_if.sink   req,
	csb_rsp_if.source rsp
);

	localparam int WORDS  = PAGE_COUNT * csb_pkg::PAGE_BITS / WORD_BITS;
	localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int BIT_W  = $clog2(WORD_BITS);
	localparam logic [csb_pkg::CODE_W-1:0] CODE_LIMIT =
		csb_pkg::CODE_W'(PAGE_COUNT * csb_pkg::PAGE_BITS);
	localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(WORDS - 1);

	localparam logic [2:0] S_SWEEP = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_WRITE = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]                     state_q;
	logic [ADDR_W-1:0]              addr_q;
	logic [ADDR_W-1:0]              last_addr_q;
	logic                           fill_q;
	logic                           sweep_rsp_q;
	logic                           query_q;
	csb_pkg::op_t                   op_q;
	logic                           member_q;
	logic [csb_pkg::STATUS_W-1:0]   status_q;
	logic                           rsp_valid_q;
	logic                           rsp_member_q;
	logic [csb_pkg::STATUS_W-1:0]   rsp_status_q;

	logic                           accept;
	logic                           out_free;
	logic                           ram_we;
	logic [WORD_BITS-1:0]           ram_wdata;
	logic [WORD_BITS-1:0]           ram_rdata;
	logic [WORD_BITS-1:0]           merged;
	logic                           merged_member;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	assign rsp.valid  = rsp_valid_q;
	assign rsp.member = rsp_member_q;
	assign rsp.status = rsp_status_q;

	csb_merge #(
		.WORD_BITS (WORD_BITS),
		.ADDR_W    (ADDR_W)
	) u_merge (
		.addr     (addr_q),
		.op       (op_q),
		.old_word (ram_rdata),
		.new_word (merged),
		.member   (merged_member)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = merged;
		if (state_q == S_SWEEP) begin
			ram_we    = 1'b1;
			ram_wdata = {WORD_BITS{fill_q}};
		end else if (state_q == S_WRITE) begin
			ram_we = !query_q;
		end
	end

	csb_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (ram_wdata),
		.re    (state_q == S_READ),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			addr_q       <= '0;
			last_addr_q  <= '0;
			fill_q       <= 1'b0;
			sweep_rsp_q  <= 1'b0;
			query_q      <= 1'b0;
			member_q     <= 1'b0;
			status_q     <= csb_pkg::ST_DONE;
		end else begin
			unique case (state_q)
				S_SWEEP: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == LAST_WORD) begin
						state_q <= sweep_rsp_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						member_q <= 1'b0;
						status_q <= csb_pkg::ST_DONE;
						query_q  <= 1'b0;
						state_q  <= S_DONE;
						unique case (req.command)
							csb_pkg::CMD_SET_CODE, csb_pkg::CMD_CLR_CODE,
							csb_pkg::CMD_QUERY: begin
								if (req.first_code >= CODE_LIMIT) begin
									status_q <= csb_pkg::ST_BEYOND;
								end else begin
									addr_q      <= req.first_code[BIT_W +: ADDR_W];
									last_addr_q <= req.first_code[BIT_W +: ADDR_W];
									query_q     <= (req.command == csb_pkg::CMD_QUERY);
									state_q     <= S_READ;
								end
							end
							csb_pkg::CMD_SET_RANGE, csb_pkg::CMD_CLR_RANGE: begin
								// reversed check wins over the bounds check
								if (req.first_code > req.last_code) begin
									status_q <= csb_pkg::ST_REVERSED;
								end else if (req.last_code >= CODE_LIMIT) begin
									status_q <= csb_pkg::ST_BEYOND;
								end else begin
									addr_q      <= req.first_code[BIT_W +: ADDR_W];
									last_addr_q <= req.last_code[BIT_W +: ADDR_W];
									state_q     <= S_READ;
								end
							end
							csb_pkg::CMD_FILL, csb_pkg::CMD_CLR_ALL: begin
								addr_q      <= '0;
								fill_q      <= (req.command == csb_pkg::CMD_FILL);
								sweep_rsp_q <= 1'b1;
								state_q     <= S_SWEEP;
							end
							default: begin
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (query_q) begin
						member_q <= merged_member;
					end
					if (addr_q == last_addr_q) begin
						state_q <= S_DONE;
					end else begin
						addr_q  <= addr_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result valid: loaded from the done state, dropped once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// operation fields and result payload carry no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q.first_code <= req.first_code;
			op_q.last_code  <= (req.command == csb_pkg::CMD_SET_RANGE ||
				req.command == csb_pkg::CMD_CLR_RANGE) ? req.last_code : req.first_code;
			op_q.set_val    <= (req.command == csb_pkg::CMD_SET_CODE ||
				req.command == csb_pkg::CMD_SET_RANGE);
		end
		if (state_q == S_DONE && out_free) begin
			rsp_member_q <= member_q;
			rsp_status_q <= status_q;
		end
	end

endmodule

FILE: rtl/csb_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module csb_ram #(
	parameter  int WIDTH = 64,
	parameter  int DEPTH = 1024,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/csb_merge.sv
// word merge unit: builds the bit mask of a range within one storage word
// and applies set or clear, also picks the queried bit; depends on csb_pkg
module csb_merge #(
	parameter int WORD_BITS = csb_pkg::WORD_BITS_DEF,
	parameter int ADDR_W    = 10
) (
	input  logic [ADDR_W-1:0]    addr,
	input  csb_pkg::op_t         op,
	input  logic [WORD_BITS-1:0] old_word,
	output logic [WORD_BITS-1:0] new_word,
	output logic                 member
);

	localparam int BIT_W = $clog2(WORD_BITS);

	logic [BIT_W-1:0]     lo;
	logic [BIT_W-1:0]     hi;
	logic [WORD_BITS-1:0] mask;

	// the range only cuts into the first and last word it covers
	always_comb begin
		lo = (addr == op.first_code[BIT_W +: ADDR_W]) ? op.first_code[BIT_W-1:0] : '0;
		hi = (addr == op.last_code[BIT_W +: ADDR_W]) ? op.last_code[BIT_W-1:0] : '1;
		for (int i = 0; i < WORD_BITS; i++) begin
			mask[i] = (BIT_W'(i) >= lo) && (BIT_W'(i) <= hi);
		end
		new_word = op.set_val ? (old_word | mask) : (old_word & ~mask);
		member   = old_word[op.first_code[BIT_W-1:0]];
	end

endmodule

FILE: rtl/csb_checker.sv
// port-level checks for the character set bitmap, bound to the top level
// depends on csb_pkg and character_set_bitmap_macros.svh
`include "character_set_bitmap_macros.svh"

module csb_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic                         rsp_member,
	input logic [csb_pkg::STATUS_W-1:0] rsp_status
);

	// one command at a time: busy in the cycle after a transaction
	`CSB_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)

	// member is only reported on a successful transaction
	`CSB_ASSERT_NOW(a_member_needs_done, rsp_valid && rsp_member, rsp_status == csb_pkg::ST_DONE)

	`CSB_ASSERT_NOW(a_status_legal, rsp_valid, rsp_status <= csb_pkg::ST_REVERSED)

	// a stalled result holds its payload
	`CSB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_member, rsp_status}))

endmodule

bind character_set_bitmap csb_checker u_csb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_member (rsp.member),
	.rsp_status (rsp.status)
);

FILE: bench/tb_top.sv
// self-checking bench for character_set_bitmap: directed and random commands over valid/ready
// depends on csb_pkg and the csb_req_if / csb_rsp_if interfaces from the rtl folder
module tb_top;

	import csb_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int CODE_LIMIT     = PAGE_COUNT_DEF * PAGE_BITS;
	localparam int CODE_MAX_FIELD = (1 << CODE_W) - 1;
	localparam int RANDOM_ITEMS   = 500;
	localparam int TRAIL_CYCLES   = 64;
	localparam int TIMEOUT_CYCLES = 1000000;
	localparam int CALM_FIRST     = 220;
	localparam int CALM_LAST      = 320;

	// command code with no operation behind it
	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

	typedef struct {
		logic [CMD_W-1:0]  command;
		logic [CODE_W-1:0] first_code;
		logic [CODE_W-1:0] last_code;
		bit                wait_idle;
	} bitmap_cmd_t;

	typedef struct packed {
		logic                member;
		logic [STATUS_W-1:0] status;
	} bitmap_rsp_t;

	logic clk;
	logic arst_n;

	csb_req_if req_ch();
	csb_rsp_if rsp_ch();

	character_set_bitmap u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// predictor state: one membership bit per code
	bit          code_member [0:CODE_LIMIT-1];
	bitmap_cmd_t pending_cmds [$];
	bitmap_rsp_t results_due [$];

	int issued_cnt   = 0;
	int accepted_cnt = 0;
	int checked_cnt  = 0;
	int fail_cnt     = 0;
	int member_hits  = 0;
	int cmd_seen [8];
	int status_seen [4];

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic bitmap_rsp_t apply_command(input logic [CMD_W-1:0] cmd,
			input logic [CODE_W-1:0] first, input logic [CODE_W-1:0] last);
		bitmap_rsp_t r;
		int c;
		r.member = 1'b0;
		r.status = ST_DONE;
		case (cmd)
			CMD_SET_CODE, CMD_CLR_CODE: begin
				if (first >= CODE_LIMIT)
					r.status = ST_BEYOND;
				else
					code_member[first] = (cmd == CMD_SET_CODE);
			end
			CMD_SET_RANGE, CMD_CLR_RANGE: begin
				// reversed order wins over the bounds check
				if (first > last)
					r.status = ST_REVERSED;
				else if (last >= CODE_LIMIT)
					r.status = ST_BEYOND;
				else
					for (c = first; c <= last; c++)
						code_member[c] = (cmd == CMD_SET_RANGE);
			end
			CMD_FILL: begin
				foreach (code_member[i]) code_member[i] = 1'b1;
			end
			CMD_CLR_ALL: begin
				foreach (code_member[i]) code_member[i] = 1'b0;
			end
			CMD_QUERY: begin
				if (first >= CODE_LIMIT)
					r.status = ST_BEYOND;
				else
					r.member = code_member[first];
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic add_cmd(input logic [CMD_W-1:0] cmd, input int first, input int last,
			input bit wait_idle);
		bitmap_cmd_t item;
		item.command    = cmd;
		item.first_code = CODE_W'(first);
		item.last_code  = CODE_W'(last);
		item.wait_idle  = wait_idle;
		pending_cmds.push_back(item);
	endtask

	// driver: a transaction stays on the bus until taken
	always @(negedge clk) begin
		bitmap_cmd_t item;
		bit calm;
		if (arst_n && !(req_ch.valid && accepted_cnt != issued_cnt)) begin
			calm = (issued_cnt >= CALM_FIRST && issued_cnt < CALM_LAST);
			if (pending_cmds.size() > 0
					&& (!pending_cmds[0].wait_idle || results_due.size() == 0)
					&& (calm || $urandom_range(0, 99) >= 30)) begin
				item = pending_cmds.pop_front();
				req_ch.command    <= item.command;
				req_ch.first_code <= item.first_code;
				req_ch.last_code  <= item.last_code;
				req_ch.valid      <= 1'b1;
				issued_cnt++;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (checked_cnt >= CALM_FIRST && checked_cnt < CALM_LAST)
			rsp_ch.ready <= 1'b1;
		else
			rsp_ch.ready <= ($urandom_range(0, 99) >= 30);
	end

	// monitor: check results first so a stray one is never matched to this edge's command
	always @(posedge clk) begin
		bitmap_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (results_due.size() == 0) begin
				$display("%0t: result with none due, member %0d status %0d",
					$time, rsp_ch.member, rsp_ch.status);
				fail_cnt++;
			end else begin
				want = results_due.pop_front();
				if (rsp_ch.member !== want.member) begin
					$display("%0t: member mismatch, expected %0d actual %0d",
						$time, want.member, rsp_ch.member);
					fail_cnt++;
				end
				if (rsp_ch.status !== want.status) begin
					$display("%0t: status mismatch, expected %0d actual %0d",
						$time, want.status, rsp_ch.status);
					fail_cnt++;
				end
			end
			if (rsp_ch.member === 1'b1)
				member_hits++;
			if (!$isunknown(rsp_ch.status))
				status_seen[rsp_ch.status]++;
			checked_cnt++;
		end
		if (arst_n && req_ch.valid && req_ch.ready) begin
			results_due.push_back(apply_command(req_ch.command, req_ch.first_code,
				req_ch.last_code));
			cmd_seen[req_ch.command]++;
			accepted_cnt++;
		end
	end

	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int n;
		int pick;
		int base;
		int span;
		int first;
		int last;
		int hot_codes [$];
		logic [CMD_W-1:0] cmd;

		req_ch.valid      = 1'b0;
		req_ch.command    = '0;
		req_ch.first_code = '0;
		req_ch.last_code  = '0;
		rsp_ch.ready      = 1'b0;
		arst_n            = 1'b0;

		// edges of the plane, out-of-range codes, reversed and overhanging ranges
		add_cmd(CMD_QUERY, 0, 0, 0);
		add_cmd(CMD_SET_CODE, 0, 0, 0);
		add_cmd(CMD_SET_CODE, CODE_LIMIT - 1, 0, 0);
		add_cmd(CMD_QUERY, 0, 0, 0);
		add_cmd(CMD_QUERY, CODE_LIMIT - 1, 0, 0);
		add_cmd(CMD_QUERY, 1, 0, 0);
		add_cmd(CMD_SET_CODE, CODE_LIMIT, 0, 0);
		add_cmd(CMD_QUERY, CODE_LIMIT, 0, 0);
		add_cmd(CMD_CLR_CODE, CODE_MAX_FIELD, CODE_MAX_FIELD, 0);
		add_cmd(CMD_SET_RANGE, 100, 300, 0);
		add_cmd(CMD_QUERY, 300, 0, 0);
		add_cmd(CMD_CLR_RANGE, 150, 160, 0);
		add_cmd(CMD_QUERY, 155, 0, 0);
		add_cmd(CMD_SET_RANGE, 500, 499, 0);
		add_cmd(CMD_CLR_RANGE, CODE_MAX_FIELD, CODE_LIMIT, 0);
		add_cmd(CMD_SET_RANGE, 65000, CODE_LIMIT, 0);
		add_cmd(CMD_CLR_RANGE, 3, CODE_MAX_FIELD, 0);
		add_cmd(CMD_QUERY, 65000, 0, 0);
		add_cmd(CMD_FILL, CODE_MAX_FIELD, CODE_MAX_FIELD, 1);
		add_cmd(CMD_QUERY, CODE_MAX_FIELD, 0, 0);
		add_cmd(CMD_CLR_CODE, 12345, 0, 0);
		add_cmd(CMD_QUERY, 12345, 0, 0);
		add_cmd(CMD_CLR_RANGE, 0, CODE_LIMIT - 1, 0);
		add_cmd(CMD_QUERY, 7, 0, 0);
		add_cmd(CMD_CLR_ALL, 0, 0, 0);
		add_cmd(CMD_UNUSED, CODE_MAX_FIELD, CODE_MAX_FIELD, 0);

		// random part: mostly work around recently touched codes so queries find members
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			span = $urandom_range(0, 200);
			if (hot_codes.size() > 0 && $urandom_range(0, 2) != 0)
				base = hot_codes[$urandom_range(0, hot_codes.size() - 1)]
					+ $urandom_range(0, 8) - 4;
			else
				base = $urandom_range(0, CODE_LIMIT - 1);
			if (base < 0)
				base = 0;
			first = base;
			last  = base + span;
			if (pick < 22)
				cmd = CMD_SET_CODE;
			else if (pick < 34)
				cmd = CMD_CLR_CODE;
			else if (pick < 64)
				cmd = CMD_QUERY;
			else if (pick < 74)
				cmd = CMD_SET_RANGE;
			else if (pick < 82)
				cmd = CMD_CLR_RANGE;
			else if (pick < 84) begin
				// wide range, walks most of the store
				cmd   = $urandom_range(0, 1) ? CMD_SET_RANGE : CMD_CLR_RANGE;
				first = $urandom_range(0, 1023);
				last  = $urandom_range(CODE_LIMIT - 1024, CODE_LIMIT - 1);
			end else if (pick < 86)
				cmd = $urandom_range(0, 1) ? CMD_FILL : CMD_CLR_ALL;
			else if (pick < 94) begin
				cmd   = CMD_W'($urandom_range(0, 7));
				first = $urandom_range(0, CODE_MAX_FIELD);
				last  = $urandom_range(0, CODE_MAX_FIELD);
			end else begin
				cmd = $urandom_range(0, 1) ? CMD_SET_RANGE : CMD_CLR_RANGE;
				if ($urandom_range(0, 1)) begin
					first = base + span + 1;
					last  = base;
				end else begin
					last = $urandom_range(CODE_LIMIT, CODE_MAX_FIELD);
				end
			end
			if (cmd != CMD_QUERY && first < CODE_LIMIT) begin
				hot_codes.push_back(first);
				if (hot_codes.size() > 64)
					void'(hot_codes.pop_front());
			end
			add_cmd(cmd, first, last, (n % 100) == 99);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() > 0 || accepted_cnt != issued_cnt)
			@(posedge clk);
		while (results_due.size() > 0)
			@(posedge clk);
		repeat (TRAIL_CYCLES) @(posedge clk);

		$display("covered %0d transactions: set %0d, clear %0d, set range %0d, clear range %0d",
			accepted_cnt, cmd_seen[CMD_SET_CODE], cmd_seen[CMD_CLR_CODE],
			cmd_seen[CMD_SET_RANGE], cmd_seen[CMD_CLR_RANGE]);
		$display("fill %0d, clear all %0d, query %0d (hits %0d), unused %0d; status %0d/%0d/%0d",
			cmd_seen[CMD_FILL], cmd_seen[CMD_CLR_ALL], cmd_seen[CMD_QUERY], member_hits,
			cmd_seen[CMD_UNUSED], status_seen[ST_DONE], status_seen[ST_BEYOND],
			status_seen[ST_REVERSED]);
		if (fail_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
